[rtl/sha256_pkg.sv]
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

   localparam int WordWidth  = 32;
   localparam int CountWidth = 61;
   localparam int Rounds     = 64;

   typedef logic [WordWidth-1:0] word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PAD80,
      ST_PADZERO,
      ST_PADLEN,
      ST_LOAD,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       put_byte;
      logic [1:0] byte_sel;   // which byte to pack: message, pad, zero, length
      logic       count_inc;
      logic       load_vars;
      logic       round;
      logic       update_cv;
      logic       emit_load;
      logic       emit_next;
      logic       finish;
      logic [2:0] len_idx;
   } cmd_type;

   localparam logic [1:0] SelMsg  = 2'd0;
   localparam logic [1:0] SelPad  = 2'd1;
   localparam logic [1:0] SelZero = 2'd2;
   localparam logic [1:0] SelLen  = 2'd3;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       block_full;
      logic [5:0] fill;
      logic       round_done;
      logic       out_busy;
   } status_type;

   localparam word_type InitValue [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type RoundConst [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (WordWidth - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sig1(input word_type x);
      sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type bsig0(input word_type x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type bsig1(input word_type x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

[rtl/sha256_hash_stream.sv]
// Top level of the SHA-256 stream hasher.
// A byte that does not fill a block returns to ST_IDLE via ST_CHECK; a full block adds
// 64 rounds (one round per cycle in the shared round unit) plus load/update.
// Last item: padding of up to 72 bytes one per cycle, one or two compressions, then
// eight digest beats, one per cycle while rsp_tready is high.
// Reset (synchronous, active high) clears fill, length and output; loads initial hash.
module sha256_hash_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] msg_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
   output logic        rsp_tlast    // last_word
);

   sha256_pkg::cmd_type    cmd;
   sha256_pkg::status_type status;
   logic [31:0] word;
   logic [2:0]  idx;

   // Control sequencing: intake, pad, round loop, emit.
   sha256_ctrl u_ctrl (
      .clock, .reset,
      .in_valid   (req_tvalid),
      .in_present (req_tuser),
      .in_last    (req_tlast),
      .in_ready   (req_tready),
      .status, .cmd);

   // Packing, schedule, rounds and digest hold.
   sha256_dpath u_dpath (
      .clock, .reset, .cmd, .status,
      .msg_byte  (req_tdata),
      .out_word  (word),
      .out_index (idx),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready));

   assign rsp_tdata = {5'd0, idx, word};
   assign rsp_tlast = (idx == 3'd7);

endmodule

[rtl/sha256_ctrl.sv]
// Controller state machine: byte intake, padding, rounds and digest output.
module sha256_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   in_present,
   input  logic                   in_last,
   output logic                   in_ready,
   input  sha256_pkg::status_type status,
   output sha256_pkg::cmd_type    cmd
);

   sha256_pkg::state_type state_ff, state_in;
   logic       last_ff, last_in;
   logic [2:0] len_ff, len_in;
   // Length bytes all written marks the final block of a message.
   logic       len_done_ff, len_done_in;
   // Pad byte already packed for the current message.
   logic       pad_done_ff, pad_done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256_pkg::ST_IDLE;
         last_ff  <= 1'b0;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
         len_ff   <= len_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      len_in   = len_ff;
      case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (in_valid && !status.out_busy) begin
               last_in  = in_last;
               state_in = sha256_pkg::ST_CHECK;
            end
         end
         sha256_pkg::ST_CHECK: begin
            // after a packed byte: compress if full, else pad or return
            if (status.block_full)     state_in = sha256_pkg::ST_LOAD;
            else if (last_ff)          state_in = sha256_pkg::ST_PAD80;
            else                       state_in = sha256_pkg::ST_IDLE;
         end
         sha256_pkg::ST_PAD80: begin
            len_in = '0;
            if (status.fill == 6'd55)      state_in = sha256_pkg::ST_PADLEN;
            else if (status.fill == 6'd63) state_in = sha256_pkg::ST_LOAD;
            else                           state_in = sha256_pkg::ST_PADZERO;
         end
         sha256_pkg::ST_PADZERO: begin
            if (status.fill == 6'd55)      state_in = sha256_pkg::ST_PADLEN;
            else if (status.fill == 6'd63) state_in = sha256_pkg::ST_LOAD;
         end
         sha256_pkg::ST_PADLEN: begin
            len_in = len_ff + 3'd1;
            if (len_ff == 3'd7) state_in = sha256_pkg::ST_LOAD;
         end
         sha256_pkg::ST_LOAD:  state_in = sha256_pkg::ST_ROUND;
         sha256_pkg::ST_ROUND: begin
            if (status.round_done) state_in = sha256_pkg::ST_UPDATE;
         end
         sha256_pkg::ST_UPDATE: begin
            if (!last_ff)          state_in = sha256_pkg::ST_IDLE;
            else if (len_done_ff)  state_in = sha256_pkg::ST_EMIT;
            else if (!pad_done_ff) state_in = sha256_pkg::ST_PAD80;
            else                   state_in = sha256_pkg::ST_PADZERO;
         end
         sha256_pkg::ST_EMIT: begin
            last_in  = 1'b0;
            state_in = sha256_pkg::ST_IDLE;
         end
         default: state_in = sha256_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_done_ff <= 1'b0;
         pad_done_ff <= 1'b0;
      end else begin
         len_done_ff <= len_done_in;
         pad_done_ff <= pad_done_in;
      end
   end

   always_comb begin
      len_done_in = len_done_ff;
      pad_done_in = pad_done_ff;
      if (state_ff == sha256_pkg::ST_PADLEN && len_ff == 3'd7) len_done_in = 1'b1;
      if (state_ff == sha256_pkg::ST_PAD80) pad_done_in = 1'b1;
      if (state_ff == sha256_pkg::ST_EMIT) begin
         len_done_in = 1'b0;
         pad_done_in = 1'b0;
      end
   end

   // Outputs.
   always_comb begin
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         sha256_pkg::ST_IDLE: begin
            in_ready      = !status.out_busy;
            cmd.put_byte  = in_valid && !status.out_busy && in_present;
            cmd.count_inc = cmd.put_byte;
            cmd.byte_sel  = sha256_pkg::SelMsg;
         end
         sha256_pkg::ST_PAD80: begin
            cmd.put_byte = 1'b1;
            cmd.byte_sel = sha256_pkg::SelPad;
         end
         sha256_pkg::ST_PADZERO: begin
            cmd.put_byte = 1'b1;
            cmd.byte_sel = sha256_pkg::SelZero;
         end
         sha256_pkg::ST_PADLEN: begin
            cmd.put_byte = 1'b1;
            cmd.byte_sel = sha256_pkg::SelLen;
            cmd.len_idx  = len_ff;
         end
         sha256_pkg::ST_LOAD:   cmd.load_vars = 1'b1;
         sha256_pkg::ST_ROUND:  cmd.round     = 1'b1;
         sha256_pkg::ST_UPDATE: cmd.update_cv = 1'b1;
         sha256_pkg::ST_EMIT: begin
            cmd.emit_load = 1'b1;
            cmd.finish    = 1'b1;
         end
         default: cmd = '0;
      endcase
      cmd.emit_next = status.out_busy;
   end

endmodule

[rtl/sha256_dpath.sv]
// Datapath: block packing, message schedule, round unit, chaining value, output.
module sha256_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  sha256_pkg::cmd_type    cmd,
   output sha256_pkg::status_type status,
   input  logic [7:0]             msg_byte,
   output logic [31:0]            out_word,
   output logic [2:0]             out_index,
   output logic                   out_valid,
   input  logic                   out_ready
);

   sha256_pkg::word_type sched_ff [16];
   sha256_pkg::word_type vars_ff  [8];
   sha256_pkg::word_type cv_ff    [8];
   sha256_pkg::word_type dig_ff   [8];
   logic [5:0]  fill_ff;
   logic        full_ff;
   logic [5:0]  rnd_ff;
   logic [sha256_pkg::CountWidth-1:0] count_ff;
   logic        ov_ff;
   logic [2:0]  oidx_ff;
   logic [7:0]  pbyte;
   logic [63:0] bits;
   sha256_pkg::word_type w_new, t1, t2, wcur;

   assign bits = {count_ff, 3'b000};

   always_comb begin
      case (cmd.byte_sel)
         sha256_pkg::SelMsg:  pbyte = msg_byte;
         sha256_pkg::SelPad:  pbyte = 8'h80;
         sha256_pkg::SelZero: pbyte = 8'h00;
         sha256_pkg::SelLen:  pbyte = bits[8*(7-cmd.len_idx) +: 8];
         default:             pbyte = 8'h00;
      endcase
   end

   // Schedule window: word 0 is the current round's word.
   assign wcur  = sched_ff[0];
   assign w_new = sched_ff[0] + sha256_pkg::sig0(sched_ff[1]) + sched_ff[9]
                  + sha256_pkg::sig1(sched_ff[14]);
   assign t1 = vars_ff[7] + sha256_pkg::bsig1(vars_ff[4])
               + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
               + sha256_pkg::RoundConst[rnd_ff] + wcur;
   assign t2 = sha256_pkg::bsig0(vars_ff[0])
               + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
                  ^ (vars_ff[1] & vars_ff[2]));

   always_ff @(posedge clock) begin
      if (cmd.put_byte) begin
         sched_ff[fill_ff[5:2]][8*(3-fill_ff[1:0]) +: 8] <= pbyte;
      end else if (cmd.round) begin
         for (int i = 0; i < 15; i++) sched_ff[i] <= sched_ff[i+1];
         sched_ff[15] <= w_new;
      end
      if (cmd.load_vars) begin
         for (int i = 0; i < 8; i++) vars_ff[i] <= cv_ff[i];
      end else if (cmd.round) begin
         vars_ff[7] <= vars_ff[6];
         vars_ff[6] <= vars_ff[5];
         vars_ff[5] <= vars_ff[4];
         vars_ff[4] <= vars_ff[3] + t1;
         vars_ff[3] <= vars_ff[2];
         vars_ff[2] <= vars_ff[1];
         vars_ff[1] <= vars_ff[0];
         vars_ff[0] <= t1 + t2;
      end
      if (cmd.emit_load) begin
         for (int i = 0; i < 8; i++) dig_ff[i] <= cv_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         full_ff  <= 1'b0;
         rnd_ff   <= '0;
         count_ff <= '0;
         ov_ff    <= 1'b0;
         oidx_ff  <= '0;
         for (int i = 0; i < 8; i++) cv_ff[i] <= sha256_pkg::InitValue[i];
      end else begin
         full_ff <= 1'b0;
         if (cmd.put_byte) begin
            fill_ff <= fill_ff + 6'd1;
            full_ff <= (fill_ff == 6'd63);
         end
         if (cmd.count_inc) count_ff <= count_ff + sha256_pkg::CountWidth'(1);
         if (cmd.load_vars) rnd_ff <= '0;
         else if (cmd.round) rnd_ff <= rnd_ff + 6'd1;
         if (cmd.update_cv) begin
            for (int i = 0; i < 8; i++) cv_ff[i] <= cv_ff[i] + vars_ff[i];
         end
         if (cmd.finish) begin
            for (int i = 0; i < 8; i++) cv_ff[i] <= sha256_pkg::InitValue[i];
            count_ff <= '0;
            fill_ff  <= '0;
            ov_ff    <= 1'b1;
            oidx_ff  <= '0;
         end else if (ov_ff && out_ready && cmd.emit_next) begin
            oidx_ff <= oidx_ff + 3'd1;
            if (oidx_ff == 3'd7) ov_ff <= 1'b0;
         end
      end
   end

   assign status.block_full     = full_ff;
   assign status.fill           = fill_ff;
   assign status.round_done     = (rnd_ff == 6'(sha256_pkg::Rounds - 1));
   assign status.out_busy       = ov_ff;

   assign out_valid = ov_ff;
   assign out_word  = dig_ff[oidx_ff];
   assign out_index = oidx_ff;

endmodule

[rtl/sha256_checker.sv]
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
module sha256_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // no intake while a digest is being delivered
   a_no_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("intake during digest");

   // tlast marks word seven
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[34:32] == 3'd7))) else $error("tlast");

   // index advances by one per beat
   a_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
      rsp_tvalid && rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1)
      else $error("index step");

   // digest starts at word zero
   a_first: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> rsp_tdata[34:32] == 3'd0) else $error("first index");

endmodule

bind sha256_hash_stream sha256_checker u_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tlast);
